// ----- sv/bmprgba_pkg.sv -----
package bmprgba_pkg;

  // Byte counter width (saturating)
  localparam int POS_W      = 36;
  localparam int LINE_W     = 18;
  localparam int DIM_W      = 16;
  localparam int CODE_W     = 3;

  // Result channel packing
  localparam int OUT_DATA_W = 104;
  localparam int OBUF_DEPTH = 4;

  // Fixed header layout
  localparam int HDR_BYTES  = 54;
  localparam int POS_SIG0   = 0;
  localparam int POS_SIG1   = 1;
  localparam int POS_OFS_LO = 10;
  localparam int POS_OFS_HI = 11;
  localparam int POS_WID_LO = 18;
  localparam int POS_WID_HI = 19;
  localparam int POS_HGT_LO = 22;
  localparam int POS_HGT_HI = 23;
  localparam int POS_DEPTH  = 28;

  localparam logic [7:0] SIG_B      = 8'h42;
  localparam logic [7:0] SIG_M      = 8'h4D;
  localparam logic [7:0] DEPTH_24   = 8'd24;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  typedef enum logic [CODE_W-1:0] {
    ST_OK         = 3'd0,
    ST_SHORT_HDR  = 3'd1,
    ST_NO_SIG     = 3'd2,
    ST_BAD_DEPTH  = 3'd3,
    ST_DATA_SHORT = 3'd4,
    ST_OFS_IN_HDR = 3'd5
  } status_t;

  // One result item
  typedef struct packed {
    logic             is_status;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [DIM_W-1:0] pixel_column;
    logic [DIM_W-1:0] pixel_row;
    status_t          status_code;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } result_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic    pix_vld;
    logic    sts_vld;
    result_t pix;
    result_t sts;
  } push_t;

endpackage

// ----- sv/bmprgba_parse.sv -----
module bmprgba_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic [7:0]           file_byte,
  input  logic                 end_of_file,
  output bmprgba_pkg::push_t   push
);

  localparam int POS_W  = bmprgba_pkg::POS_W;
  localparam int LINE_W = bmprgba_pkg::LINE_W;
  localparam int DIM_W  = bmprgba_pkg::DIM_W;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [DIM_W-1:0]    ofs_r, ofs_nxt;
  logic [DIM_W-1:0]    wid_r, wid_nxt;
  logic [DIM_W-1:0]    hgt_r, hgt_nxt;
  logic                four_r, four_nxt;
  logic [LINE_W-1:0]   lbc_r, lbc_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    frow_r, frow_nxt;
  logic [1:0]          chan_r, chan_nxt;
  logic [23:0]         asm_r, asm_nxt;
  bmprgba_pkg::status_t err_r, err_nxt;

  logic [LINE_W-1:0]   pix_bytes;
  logic [LINE_W-1:0]   scan;
  logic [LINE_W-1:0]   lbc_inc;
  logic [POS_W-1:0]    pos_inc;
  logic [1:0]          chan_last;
  logic                active;
  logic                row_end;
  logic                data_short;
  bmprgba_pkg::status_t err_hdr;
  bmprgba_pkg::status_t code;

  // Scanline geometry from header values
  always_comb begin
    pix_bytes = four_r ? {wid_r, 2'b00} : ({2'b00, wid_r} + {1'b0, wid_r, 1'b0});
    scan      = (pix_bytes + LINE_W'(3)) & ~LINE_W'(3);
    chan_last = four_r ? 2'd3 : 2'd2;
    lbc_inc   = lbc_r + LINE_W'(1);
    pos_inc   = (pos_r != '1) ? pos_r + POS_W'(1) : pos_r;
    active    = (err_r == bmprgba_pkg::ST_OK)
             && (pos_r >= POS_W'(bmprgba_pkg::HDR_BYTES))
             && (ofs_r >= DIM_W'(bmprgba_pkg::HDR_BYTES))
             && (pos_r >= {{(POS_W-DIM_W){1'b0}}, ofs_r})
             && (frow_r < hgt_r)
             && (scan != '0);
    row_end   = active && (lbc_inc >= scan);
  end

  // Signature and depth checks for this byte
  always_comb begin
    err_hdr = err_r;
    if (byte_vld && err_r == bmprgba_pkg::ST_OK) begin
      if (pos_r == POS_W'(bmprgba_pkg::POS_SIG0) && file_byte != bmprgba_pkg::SIG_B)
        err_hdr = bmprgba_pkg::ST_NO_SIG;
      if (pos_r == POS_W'(bmprgba_pkg::POS_SIG1) && file_byte != bmprgba_pkg::SIG_M)
        err_hdr = bmprgba_pkg::ST_NO_SIG;
      if (pos_r == POS_W'(bmprgba_pkg::POS_DEPTH) && file_byte != bmprgba_pkg::DEPTH_24 &&
          file_byte != bmprgba_pkg::DEPTH_32)
        err_hdr = bmprgba_pkg::ST_BAD_DEPTH;
    end
  end

  // Header capture, pixel assembly and status
  always_comb begin
    pos_nxt  = pos_r;
    ofs_nxt  = ofs_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    four_nxt = four_r;
    lbc_nxt  = lbc_r;
    col_nxt  = col_r;
    frow_nxt = frow_r;
    chan_nxt = chan_r;
    asm_nxt  = asm_r;
    err_nxt  = err_hdr;
    push     = '0;

    if (byte_vld) begin
      // header fields
      if (pos_r == POS_W'(bmprgba_pkg::POS_OFS_LO)) ofs_nxt[7:0]  = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_OFS_HI)) ofs_nxt[15:8] = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_WID_LO)) wid_nxt[7:0]  = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_WID_HI)) wid_nxt[15:8] = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_HGT_LO)) hgt_nxt[7:0]  = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_HGT_HI)) hgt_nxt[15:8] = file_byte;
      if (pos_r == POS_W'(bmprgba_pkg::POS_DEPTH))
        four_nxt = (file_byte == bmprgba_pkg::DEPTH_32);

      // pixel data
      if (active) begin
        if (lbc_r < pix_bytes) begin
          if (chan_r == chan_last) begin
            push.pix_vld          = 1'b1;
            push.pix.red          = file_byte;
            push.pix.green        = four_r ? asm_r[23:16] : asm_r[15:8];
            push.pix.blue         = four_r ? asm_r[15:8]  : asm_r[7:0];
            push.pix.alpha        = four_r ? asm_r[7:0]   : bmprgba_pkg::ALPHA_FULL;
            push.pix.pixel_column = col_r;
            push.pix.pixel_row    = hgt_r - DIM_W'(1) - frow_r;
            chan_nxt = '0;
            asm_nxt  = '0;
            col_nxt  = col_r + DIM_W'(1);
          end else begin
            case (chan_r)
              2'd0:    asm_nxt[7:0]   = file_byte;
              2'd1:    asm_nxt[15:8]  = file_byte;
              default: asm_nxt[23:16] = file_byte;
            endcase
            chan_nxt = chan_r + 2'd1;
          end
        end
        lbc_nxt = lbc_inc;
        if (lbc_inc >= scan) begin
          lbc_nxt  = '0;
          col_nxt  = '0;
          chan_nxt = '0;
          asm_nxt  = '0;
          frow_nxt = frow_r + DIM_W'(1);
        end
      end

      // saturating byte count
      pos_nxt = pos_inc;

      // end of file: status, then back to reset
      if (end_of_file) begin
        push.sts_vld           = 1'b1;
        push.sts.is_status     = 1'b1;
        push.sts.status_code   = code;
        push.sts.image_width   = wid_nxt;
        push.sts.image_height  = hgt_nxt;
        pos_nxt  = '0;
        ofs_nxt  = '0;
        wid_nxt  = '0;
        hgt_nxt  = '0;
        four_nxt = 1'b0;
        lbc_nxt  = '0;
        col_nxt  = '0;
        frow_nxt = '0;
        chan_nxt = '0;
        asm_nxt  = '0;
        err_nxt  = bmprgba_pkg::ST_OK;
      end
    end
  end

  // Pixel data is complete once every row has been walked; with an empty
  // image the data only has to reach the pixel offset.
  always_comb begin
    if (wid_r == '0 || hgt_r == '0)
      data_short = pos_inc < {{(POS_W-DIM_W){1'b0}}, ofs_r};
    else
      data_short = (frow_r + DIM_W'(row_end)) < hgt_r;
  end

  // Status priority
  always_comb begin
    if (pos_inc < POS_W'(bmprgba_pkg::HDR_BYTES))
      code = bmprgba_pkg::ST_SHORT_HDR;
    else if (err_hdr != bmprgba_pkg::ST_OK)
      code = err_hdr;
    else if (ofs_r < DIM_W'(bmprgba_pkg::HDR_BYTES))
      code = bmprgba_pkg::ST_OFS_IN_HDR;
    else if (data_short)
      code = bmprgba_pkg::ST_DATA_SHORT;
    else
      code = bmprgba_pkg::ST_OK;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ofs_r  <= '0;
      wid_r  <= '0;
      hgt_r  <= '0;
      four_r <= 1'b0;
      lbc_r  <= '0;
      col_r  <= '0;
      frow_r <= '0;
      chan_r <= '0;
      asm_r  <= '0;
      err_r  <= bmprgba_pkg::ST_OK;
    end else begin
      pos_r  <= pos_nxt;
      ofs_r  <= ofs_nxt;
      wid_r  <= wid_nxt;
      hgt_r  <= hgt_nxt;
      four_r <= four_nxt;
      lbc_r  <= lbc_nxt;
      col_r  <= col_nxt;
      frow_r <= frow_nxt;
      chan_r <= chan_nxt;
      asm_r  <= asm_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ----- sv/bmprgba_obuf.sv -----
module bmprgba_obuf #(
  parameter int DEPTH = bmprgba_pkg::OBUF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmprgba_pkg::push_t   push,
  output logic                 room,
  output logic                 rd_vld,
  input  logic                 rd_rdy,
  output bmprgba_pkg::result_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bmprgba_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;
  logic [1:0]       n_push;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Two free entries needed: one byte can produce a pixel and a status
  assign room    = cnt_r <= CNT_W'(DEPTH - 2);
  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign pop     = rd_vld && rd_rdy;

  // Pointer and count update
  always_comb begin
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    n_push     = {1'b0, push.pix_vld} + {1'b0, push.sts_vld};
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) wr_ptr_nxt = wr_ptr_p1;
    else if (n_push == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry writes; pixel goes ahead of status
  always_ff @(posedge clk) begin
    if (push.pix_vld) begin
      mem_r[wr_ptr_r] <= push.pix;
      if (push.sts_vld) mem_r[wr_ptr_p1] <= push.sts;
    end else if (push.sts_vld) begin
      mem_r[wr_ptr_r] <= push.sts;
    end
  end

endmodule

// ----- sv/bmp_to_rgba_stream_decoder.sv -----
// Channel  Dir  Ports                             Contents
// in       in   in_tvalid/in_tready/in_tdata[7:0] one file byte; in_tlast = end of file
//                in_tlast
// out      out  out_tvalid/out_tready/out_tdata   pixel or status request;
//                out_tuser                        out_tuser = 1 on status
//
// With room, one file byte is taken per cycle and decoded in the cycle it is
// accepted and its results land in a small output queue the same edge.
// A byte may produce up to two results (last pixel plus status), so input is
// held off while fewer than two queue entries are free.
// Synchronous active-low reset clears all parser state and empties the queue.
// A stalled output stops input once fewer than two queue entries are free.
module bmp_to_rgba_stream_decoder #(
  parameter int OBUF_DEPTH = bmprgba_pkg::OBUF_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] file_byte
  input  logic                                in_tlast,   // end_of_file
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] pixel_column,
  // [63:48] pixel_row, [66:64] status_code, [82:67] image_width,
  // [98:83] image_height, upper bits zero
  output logic [bmprgba_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                out_tuser   // is_status
);

  bmprgba_pkg::push_t   push;
  bmprgba_pkg::result_t res;
  logic                 room;

  assign in_tready = room;

  bmprgba_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (in_tvalid && room),
    .file_byte   (in_tdata),
    .end_of_file (in_tlast),
    .push        (push)
  );

  bmprgba_obuf #(
    .DEPTH (OBUF_DEPTH)
  ) u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .rd_vld  (out_tvalid),
    .rd_rdy  (out_tready),
    .rd_data (res)
  );

  // Result packing, first field lowest
  assign out_tuser = res.is_status;
  assign out_tdata = {5'b0, res.image_height, res.image_width, res.status_code,
                      res.pixel_row, res.pixel_column, res.alpha, res.blue,
                      res.green, res.red};

endmodule
